// ===== rtl/core/stio_pkg.sv =====
package stio_pkg;

	// Fixed widths of the ports.
	localparam int INDEX_BITS  = 32;
	localparam int OFFSET_BITS = 36;
	localparam int CFG_BITS    = 64;
	localparam int DIMS_BITS   = 3;

	// Register reset values.
	localparam logic [CFG_BITS-1:0]  SHAPE_RESET  = 64'h0001_0001_0001_0001;
	localparam logic [CFG_BITS-1:0]  STRIDE_RESET = 64'h0;
	localparam logic [DIMS_BITS-1:0] DIMS_RESET   = 3'd1;

	// Register indexes on the configuration channel.
	typedef enum logic [2:0] {
		REG_DST_SHAPE   = 3'd0,
		REG_DST_STRIDES = 3'd1,
		REG_DST_DIMS    = 3'd2,
		REG_SRC_SHAPE   = 3'd3,
		REG_SRC_STRIDES = 3'd4,
		REG_SRC_DIMS    = 3'd5
	} stio_reg_t;

	// What one side's pipeline hands to the top level.
	typedef struct packed {
		logic                   vld;
		logic                   err;
		logic [OFFSET_BITS-1:0] offset;
	} stio_side_res_t;

endpackage

// ===== rtl/core/stio_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The divisor must be held steady while items are in flight.
module stio_div #(
	parameter int DW = 32,
	parameter int VW = 16,
	parameter int PW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [DW-1:0] in_quo,
	input  logic [PW-1:0] in_pass,
	input  logic [VW-1:0] divisor,
	output logic          out_vld,
	output logic [DW-1:0] out_quo,
	output logic [VW-1:0] out_rem,
	output logic [PW-1:0] out_pass
);

	logic          vld_s  [DW+1];
	logic [DW-1:0] quo_s  [DW+1];
	logic [VW-1:0] rem_s  [DW+1];
	logic [PW-1:0] pass_s [DW+1];

	assign vld_s[0]  = in_vld;
	assign quo_s[0]  = in_quo;
	assign rem_s[0]  = '0;
	assign pass_s[0] = in_pass;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] trial;
		logic        ge;

		// Bring down the next dividend bit and try a subtraction.
		assign trial = {rem_s[k], quo_s[k][DW-1]};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
			quo_s[k+1]  <= {quo_s[k][DW-2:0], ge};
			pass_s[k+1] <= pass_s[k];
		end
	end

	assign out_vld  = vld_s[DW];
	assign out_quo  = quo_s[DW];
	assign out_rem  = rem_s[DW];
	assign out_pass = pass_s[DW];

endmodule

// ===== rtl/core/stio_side.sv =====
// One side's address path: mixed-radix split of the index from the last
// dimension down, then coordinate times stride and a final sum.
module stio_side #(
	parameter int MAX_DIMS       = 4,
	parameter int DIM_FIELD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic [stio_pkg::INDEX_BITS-1:0]      index,
	input  logic [DIM_FIELD_BITS-1:0]            size   [MAX_DIMS],
	input  logic [DIM_FIELD_BITS-1:0]            stride [MAX_DIMS],
	input  logic                                 zero_size,
	output stio_pkg::stio_side_res_t             res
);

	localparam int DFB = DIM_FIELD_BITS;
	localparam int CW  = MAX_DIMS * DFB;
	localparam int PB  = 2 * DFB;
	localparam int IB  = stio_pkg::INDEX_BITS;
	localparam int OB  = stio_pkg::OFFSET_BITS;

	logic          v_n [MAX_DIMS];
	logic [IB-1:0] q_n [MAX_DIMS];
	logic [CW-1:0] c_n [MAX_DIMS];

	assign v_n[MAX_DIMS-1] = in_vld;
	assign q_n[MAX_DIMS-1] = index;
	assign c_n[MAX_DIMS-1] = '0;

	for (genvar d = MAX_DIMS - 1; d >= 1; d--) begin : g_dim
		logic           div_vld;
		logic [IB-1:0]  div_quo;
		logic [DFB-1:0] div_rem;
		logic [CW-1:0]  div_pass;

		stio_div #(.DW(IB), .VW(DFB), .PW(CW)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (v_n[d]),
			.in_quo   (q_n[d]),
			.in_pass  (c_n[d]),
			.divisor  (size[d]),
			.out_vld  (div_vld),
			.out_quo  (div_quo),
			.out_rem  (div_rem),
			.out_pass (div_pass)
		);

		assign v_n[d-1] = div_vld;
		assign q_n[d-1] = div_quo;
		assign c_n[d-1] = div_pass | (CW'(div_rem) << (d * DFB));
	end

	logic [DFB-1:0] coord [MAX_DIMS];
	logic           err_now;

	always_comb begin
		for (int i = 0; i < MAX_DIMS; i++) begin
			coord[i] = c_n[0][i*DFB +: DFB];
		end
		coord[0] = q_n[0][DFB-1:0];
		// What is left after the inner dimensions must fit in dimension zero.
		err_now  = zero_size || (q_n[0] >= IB'(size[0]));
	end

	logic          vld_s1;
	logic          err_s1;
	logic [PB-1:0] prod_s1 [MAX_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= v_n[0];
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err_now;
		for (int i = 0; i < MAX_DIMS; i++) begin
			prod_s1[i] <= PB'(coord[i]) * PB'(stride[i]);
		end
	end

	logic [OB-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			sum = sum + OB'(prod_s1[i]);
		end
	end

	logic          vld_s2;
	logic          err_s2;
	logic [OB-1:0] offset_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s2    <= err_s1;
		offset_s2 <= sum;
	end

	assign res.vld    = vld_s2;
	assign res.err    = err_s2;
	assign res.offset = offset_s2;

endmodule

// ===== rtl/core/strided_index_to_offsets.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// input    | start, busy             | element_index
// result   | done (one-cycle strobe) | src_offset, dst_offset, index_error
// config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// One transaction is taken every clock cycle; busy is always low.
// Each inner dimension runs through one 32-stage bit-per-cycle divider, then
// come a multiply stage, a sum stage and the output register. Reset clears
// only the valid bits and the configuration registers. The receiver cannot
// stall, so nothing in the pipeline ever holds.
module strided_index_to_offsets #(
	parameter int MAX_DIMS       = 4,
	parameter int DIM_FIELD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [stio_pkg::INDEX_BITS-1:0]     element_index,
	output logic                                done,
	output logic [stio_pkg::OFFSET_BITS-1:0]    src_offset,
	output logic [stio_pkg::OFFSET_BITS-1:0]    dst_offset,
	output logic                                index_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [stio_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int DFB = DIM_FIELD_BITS;
	localparam logic [stio_pkg::DIMS_BITS-1:0] DIMS_MAX = stio_pkg::DIMS_BITS'(MAX_DIMS);

	// The pipeline never stalls, so an item is accepted whenever start is high.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [stio_pkg::CFG_BITS-1:0]  dst_shape_q, dst_strides_q, src_shape_q, src_strides_q;
	logic [stio_pkg::DIMS_BITS-1:0] dst_dims_q, src_dims_q;

	// Configuration registers. Writes to undefined indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_shape_q   <= stio_pkg::SHAPE_RESET;
			dst_strides_q <= stio_pkg::STRIDE_RESET;
			dst_dims_q    <= stio_pkg::DIMS_RESET;
			src_shape_q   <= stio_pkg::SHAPE_RESET;
			src_strides_q <= stio_pkg::STRIDE_RESET;
			src_dims_q    <= stio_pkg::DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				stio_pkg::REG_DST_SHAPE:   dst_shape_q   <= cfg_data;
				stio_pkg::REG_DST_STRIDES: dst_strides_q <= cfg_data;
				stio_pkg::REG_DST_DIMS:    dst_dims_q    <= cfg_data[stio_pkg::DIMS_BITS-1:0];
				stio_pkg::REG_SRC_SHAPE:   src_shape_q   <= cfg_data;
				stio_pkg::REG_SRC_STRIDES: src_strides_q <= cfg_data;
				stio_pkg::REG_SRC_DIMS:    src_dims_q    <= cfg_data[stio_pkg::DIMS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective per-dimension values. A dimension that is not in use acts as
	// size one with stride zero, so it splits off a zero coordinate and adds
	// nothing. Dims above the maximum saturate.
	logic [DFB-1:0]                 src_size [MAX_DIMS];
	logic [DFB-1:0]                 src_str  [MAX_DIMS];
	logic [DFB-1:0]                 dst_size [MAX_DIMS];
	logic [DFB-1:0]                 dst_str  [MAX_DIMS];
	logic                           src_zero, dst_zero;
	logic [stio_pkg::DIMS_BITS-1:0] src_n, dst_n;

	always_comb begin
		src_n    = (src_dims_q > DIMS_MAX) ? DIMS_MAX : src_dims_q;
		dst_n    = (dst_dims_q > DIMS_MAX) ? DIMS_MAX : dst_dims_q;
		src_zero = 1'b0;
		dst_zero = 1'b0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (stio_pkg::DIMS_BITS'(i) < src_n) begin
				src_size[i] = src_shape_q[i*DFB +: DFB];
				src_str[i]  = src_strides_q[i*DFB +: DFB];
				src_zero    = src_zero | (src_shape_q[i*DFB +: DFB] == '0);
			end else begin
				src_size[i] = DFB'(1);
				src_str[i]  = '0;
			end
			if (stio_pkg::DIMS_BITS'(i) < dst_n) begin
				dst_size[i] = dst_shape_q[i*DFB +: DFB];
				dst_str[i]  = dst_strides_q[i*DFB +: DFB];
				dst_zero    = dst_zero | (dst_shape_q[i*DFB +: DFB] == '0);
			end else begin
				dst_size[i] = DFB'(1);
				dst_str[i]  = '0;
			end
		end
	end

	stio_pkg::stio_side_res_t src_res, dst_res;

	stio_side #(.MAX_DIMS(MAX_DIMS), .DIM_FIELD_BITS(DFB)) u_src (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.index     (element_index),
		.size      (src_size),
		.stride    (src_str),
		.zero_size (src_zero),
		.res       (src_res)
	);

	stio_side #(.MAX_DIMS(MAX_DIMS), .DIM_FIELD_BITS(DFB)) u_dst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.index     (element_index),
		.size      (dst_size),
		.stride    (dst_str),
		.zero_size (dst_zero),
		.res       (dst_res)
	);

	// Both sides have the same latency, so their valid bits line up.
	// An index out of range on either side zeroes both offsets.
	logic                            bad;
	logic                            done_q, err_q;
	logic [stio_pkg::OFFSET_BITS-1:0] src_off_q, dst_off_q;

	assign bad = src_res.err | dst_res.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= src_res.vld & dst_res.vld;
		end
	end

	always_ff @(posedge clk) begin
		err_q     <= bad;
		src_off_q <= bad ? '0 : src_res.offset;
		dst_off_q <= bad ? '0 : dst_res.offset;
	end

	assign done        = done_q;
	assign index_error = err_q;
	assign src_offset  = src_off_q;
	assign dst_offset  = dst_off_q;

endmodule

// ===== rtl/core/stio_checker.sv =====
module stio_checker #(
	parameter int MAX_DIMS = 4
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [stio_pkg::OFFSET_BITS-1:0]  src_offset,
	input logic [stio_pkg::OFFSET_BITS-1:0]  dst_offset,
	input logic                              index_error,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	localparam int LAT = 32 * (MAX_DIMS - 1) + 3;

	// Every accepted transaction comes out as a result with done set.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (src_offset == '0 && dst_offset == '0))
		else $error("error result carries nonzero offsets");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind strided_index_to_offsets stio_checker #(.MAX_DIMS(MAX_DIMS)) u_stio_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.src_offset  (src_offset),
	.dst_offset  (dst_offset),
	.index_error (index_error),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);

// ===== tb/stio_offset_checker.sv =====
`timescale 1ns / 1ps

module stio_offset_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [stio_pkg::INDEX_BITS-1:0]  element_index,
	input  logic                             done,
	input  logic [stio_pkg::OFFSET_BITS-1:0] src_offset,
	input  logic [stio_pkg::OFFSET_BITS-1:0] dst_offset,
	input  logic                             index_error,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [stio_pkg::CFG_BITS-1:0]    cfg_data,
	output int                               mismatches,
	output int                               pending
);
	import stio_pkg::*;

	typedef struct {
		logic [OFFSET_BITS-1:0] src;
		logic [OFFSET_BITS-1:0] dst;
		logic                   err;
	} offset_pair_t;

	offset_pair_t expected_pairs[$];

	logic [CFG_BITS-1:0]  dst_shape_q, dst_strides_q, src_shape_q, src_strides_q;
	logic [DIMS_BITS-1:0] dst_dims_q, src_dims_q;

	assign pending = expected_pairs.size();

	function automatic int dims_in_use(logic [DIMS_BITS-1:0] d);
		return (d > 4) ? 4 : int'(d);
	endfunction

	function automatic logic [63:0] size_at(logic [CFG_BITS-1:0] packed_val, int i);
		return {48'd0, packed_val[i*16 +: 16]};
	endfunction

	function automatic logic [63:0] element_total(logic [CFG_BITS-1:0] shape,
			logic [DIMS_BITS-1:0] dims);
		logic [63:0] total;
		total = 64'd1;
		for (int i = 0; i < dims_in_use(dims); i++)
			total = total * size_at(shape, i);
		return total;
	endfunction

	// Peel coordinates off from the outermost dimension down, weighting each by its stride.
	function automatic logic [OFFSET_BITS-1:0] side_offset(logic [63:0] idx,
			logic [CFG_BITS-1:0] shape, logic [CFG_BITS-1:0] strides,
			logic [DIMS_BITS-1:0] dims);
		logic [63:0] rest, acc, place;
		int n;
		n = dims_in_use(dims);
		rest = idx;
		acc = 64'd0;
		for (int i = 0; i < n; i++) begin
			place = 64'd1;
			for (int j = i + 1; j < n; j++)
				place = place * size_at(shape, j);
			if (place == 0)
				return '0;
			acc = acc + (rest / place) * size_at(strides, i);
			rest = rest % place;
		end
		return acc[OFFSET_BITS-1:0];
	endfunction

	function automatic offset_pair_t map_index(logic [INDEX_BITS-1:0] raw);
		offset_pair_t r;
		logic [63:0] idx;
		idx = {32'd0, raw};
		r.err = (idx >= element_total(src_shape_q, src_dims_q)) ||
			(idx >= element_total(dst_shape_q, dst_dims_q));
		r.src = r.err ? '0 : side_offset(idx, src_shape_q, src_strides_q, src_dims_q);
		r.dst = r.err ? '0 : side_offset(idx, dst_shape_q, dst_strides_q, dst_dims_q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		offset_pair_t want;
		if (!arst_n) begin
			dst_shape_q   <= SHAPE_RESET;
			src_shape_q   <= SHAPE_RESET;
			dst_strides_q <= STRIDE_RESET;
			src_strides_q <= STRIDE_RESET;
			dst_dims_q    <= DIMS_RESET;
			src_dims_q    <= DIMS_RESET;
			mismatches    <= 0;
			expected_pairs.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DST_SHAPE:   dst_shape_q   <= cfg_data;
					REG_DST_STRIDES: dst_strides_q <= cfg_data;
					REG_DST_DIMS:    dst_dims_q    <= cfg_data[DIMS_BITS-1:0];
					REG_SRC_SHAPE:   src_shape_q   <= cfg_data;
					REG_SRC_STRIDES: src_strides_q <= cfg_data;
					REG_SRC_DIMS:    src_dims_q    <= cfg_data[DIMS_BITS-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_pairs.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected", $time);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_pairs.pop_front();
					if (want.src !== src_offset || want.dst !== dst_offset ||
							want.err !== index_error) begin
						if (mismatches < 10)
							$display("%0t: expected src=%h dst=%h err=%b, got src=%h dst=%h err=%b",
								$time, want.src, want.dst, want.err,
								src_offset, dst_offset, index_error);
						mismatches <= mismatches + 1;
					end
				end
			end
			// Users must change registers only while idle; the block does not enforce it.
			if (start && !busy)
				expected_pairs.push_back(map_index(element_index));
		end
	end

endmodule

// ===== tb/tb_strided_index_to_offsets.sv =====
`timescale 1ns / 1ps

module tb_strided_index_to_offsets;
	import stio_pkg::*;

	// The full pipeline depth, used by drain as a margin.
	localparam int LATENCY     = 32 * 3 + 3;
	localparam int CYCLE_LIMIT = 400000;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [INDEX_BITS-1:0]  element_index;
	logic                   done;
	logic [OFFSET_BITS-1:0] src_offset;
	logic [OFFSET_BITS-1:0] dst_offset;
	logic                   index_error;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [2:0]             cfg_index;
	logic [CFG_BITS-1:0]    cfg_data;

	int mismatches;
	int pending;
	int cycles;
	int items_sent;
	int reg_writes;
	int gap_pct;

	// The index range that the current shapes allow, used to aim most indexes in range.
	logic [63:0] valid_span;

	strided_index_to_offsets dut (.*);

	stio_offset_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("strided_index_to_offsets verification failed");
			$finish;
		end
	end

	// One register transaction; the ready read here is the value from before the edge.
	task automatic write_reg(stio_reg_t idx, logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	function automatic logic [63:0] span_of(logic [63:0] shape, logic [2:0] dims);
		logic [63:0] total;
		int n;
		total = 64'd1;
		n = (dims > 4) ? 4 : int'(dims);
		for (int i = 0; i < n; i++)
			total = total * shape[i*16 +: 16];
		return total;
	endfunction

	// Writes every register; the block must be idle when this is called.
	task automatic load_shapes(logic [63:0] dshape, logic [63:0] dstr, logic [2:0] ddims,
			logic [63:0] sshape, logic [63:0] sstr, logic [2:0] sdims);
		logic [63:0] a, b;
		write_reg(REG_DST_SHAPE, dshape);
		write_reg(REG_DST_STRIDES, dstr);
		write_reg(REG_DST_DIMS, {61'd0, ddims});
		write_reg(REG_SRC_SHAPE, sshape);
		write_reg(REG_SRC_STRIDES, sstr);
		write_reg(REG_SRC_DIMS, {61'd0, sdims});
		a = span_of(dshape, ddims);
		b = span_of(sshape, sdims);
		valid_span = (a < b) ? a : b;
	endtask

	// Present one index, holding start until the block takes the transaction.
	task automatic send_index(logic [INDEX_BITS-1:0] idx);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		element_index <= idx;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Ends a burst: drop start, let results drain, then allow for the full pipeline depth.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [INDEX_BITS-1:0] pick_index;
		logic [63:0] hi;
		if ($urandom_range(99) < 25 || valid_span == 0)
			return $urandom;
		hi = valid_span + 2;
		if (hi > 64'hFFFF_FFFF)
			return $urandom;
		return $urandom_range(0, int'(hi));
	endfunction

	// Mostly small sizes so that indexes land in range; now and then zero, the widest or a random size.
	function automatic logic [15:0] pick_size;
		case ($urandom_range(19))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [63:0] pick_shape;
		return {pick_size(), pick_size(), pick_size(), pick_size()};
	endfunction

	initial begin
		logic [63:0] strides_a, strides_b;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		element_index <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_DST_SHAPE;
		cfg_data      <= '0;
		cycles        = 0;
		items_sent    = 0;
		reg_writes    = 0;
		gap_pct       = 14;
		valid_span    = 64'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shapes: a single element on each side, so only index zero is legal.
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFF_FFFF);
		drain();

		// Four dimensions on both sides, 120 elements each, including the last legal index.
		load_shapes(64'h0005_0004_0003_0002, 64'h0004_0003_0002_0001, 3'd4,
			64'h0002_0003_0004_0005, 64'h0001_0010_0100_1000, 3'd4);
		send_index(32'd0);
		send_index(32'd37);
		send_index(32'd119);
		send_index(32'd120);
		drain();

		// Scalar destination against a source whose dimension count saturates at four.
		load_shapes(64'h0009_0009_0009_0009, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0,
			64'h0002_0002_0002_0002, 64'h0008_0004_0002_0001, 3'd7);
		send_index(32'd0);
		send_index(32'd1);
		drain();

		// A zero size in use on the destination; zero fields past the source dims are ignored.
		load_shapes(64'h0004_0003_0000_0003, 64'h0001_0001_0001_0001, 3'd2,
			64'h0000_0000_0006_0005, 64'h0000_0000_0007_0003, 3'd2);
		send_index(32'd0);
		send_index(32'd5);
		drain();

		// Widest sizes and strides: the element count exceeds every index, and offsets still fit in 36 bits.
		load_shapes(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd4,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd4);
		send_index(32'd0);
		send_index(32'hFFFF_FFFF);
		send_index(32'h8000_0001);
		drain();

		// Random phases: sender lightly idle, then heavily idle, then streaming back to back.
		for (int phase = 0; phase < 13; phase++) begin
			gap_pct = (phase < 5) ? 14 : (phase < 9) ? 53 : 0;
			strides_a = {$urandom, $urandom};
			strides_b = {$urandom, $urandom};
			load_shapes(pick_shape(), strides_a, 3'($urandom_range(7)),
				pick_shape(), strides_b, 3'($urandom_range(7)));
			for (int k = 0; k < 50; k++) begin
				// Once in the run, hold off until the pipeline has fully emptied.
				if (phase == 6 && k == 25) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
				send_index(pick_index());
			end
			drain();
		end

		$display("Mapped %0d indexes across %0d register writes, covering scalar, saturated,",
			items_sent, reg_writes);
		$display("zero-size and widest shapes with light, heavy and no sender gaps.");
		if (mismatches == 0 && pending == 0)
			$display("strided_index_to_offsets verification clean");
		else
			$display("strided_index_to_offsets verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/stio_pkg.sv
rtl/core/stio_div.sv
rtl/core/stio_side.sv
rtl/core/strided_index_to_offsets.sv
rtl/core/stio_checker.sv
tb/stio_offset_checker.sv
tb/tb_strided_index_to_offsets.sv
